### sv/ttsd_pkg.sv
package ttsd_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POINT_ROTATION  = 3'd0,
    REG_SCREEN_WIDTH    = 3'd1,
    REG_SCREEN_HEIGHT   = 3'd2,
    REG_LONG_PRESS_MS   = 3'd3,
    REG_TAP_MOVE_LIMIT  = 3'd4,
    REG_SWIPE_THRESHOLD = 3'd5,
    REG_SWIPE_INVERT    = 3'd6
  } cfg_reg_t;

  // Field widths fixed by the report format and the result format
  localparam int RAW_W    = 12;  // coordinate as read from the report
  localparam int SIZE_W   = 13;  // screen size register
  localparam int HOLD_W   = 16;  // long-press register
  localparam int OUT_W    = 16;  // coordinate result fields
  localparam int STAMP_W  = 32;  // timestamp input field
  localparam int SIZE_X_W = 17;  // room for size minus one at coordinate widths up to 17 bits

  localparam logic [3:0] TOUCH_CNT_MASK = 4'hF;

  // Register reset values
  localparam logic [1:0]        ROTATION_RST  = 2'd0;
  localparam logic [SIZE_W-1:0] WIDTH_RST     = 13'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RST    = 13'd480;
  localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [RAW_W-1:0]  MOVE_LIMIT_RST = 12'd18;
  localparam logic [RAW_W-1:0]  SWIPE_THR_RST  = 12'd36;

  // Quarter-turn codes
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // Two-bit signed direction codes
  localparam logic signed [1:0] DIR_POS  = 2'sb01;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;
  localparam logic signed [1:0] DIR_NONE = 2'sb00;

endpackage

### sv/touch_tap_swipe_detector.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------------
// in_       | in_valid/in_stall  | read_ok, status_byte, x/y high/low, now_ms
// out_      | out_valid/out_stall| touching, live x/y, tap, tap x/y, swipe, dirs,
//           |                    | swiping
// cfg_      | cfg_we             | cfg_addr, cfg_wdata
//
// One poll per cycle sustained while the result is not stalled; the result is registered after stage one.
// Stage one holds the parsed report, stage two updates the press state and
// loads the result register in the same cycle, so the next poll sees it.
// Reset (synchronous, rst_n low) clears both stage valid flags and the press state
// and sets the config registers to their defaults. A stalled result holds; the
// input stage keeps accepting until it is full behind a stalled result.
module touch_tap_swipe_detector #(
  parameter int COORD_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_we,
  input  logic [ttsd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ttsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_read_ok,
  input  logic [7:0]                        in_status_byte,
  input  logic [7:0]                        in_x_high,
  input  logic [7:0]                        in_x_low,
  input  logic [7:0]                        in_y_high,
  input  logic [7:0]                        in_y_low,
  input  logic [ttsd_pkg::STAMP_W-1:0]      in_now_ms,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_touching,
  output logic [ttsd_pkg::OUT_W-1:0]        out_live_x,
  output logic [ttsd_pkg::OUT_W-1:0]        out_live_y,
  output logic                              out_tap_event,
  output logic [ttsd_pkg::OUT_W-1:0]        out_tap_x,
  output logic [ttsd_pkg::OUT_W-1:0]        out_tap_y,
  output logic                              out_swipe_event,
  output logic signed [1:0]                 out_swipe_dir_x,
  output logic signed [1:0]                 out_swipe_dir_y,
  output logic                              out_swiping
);
  import ttsd_pkg::*;

  // Configuration registers
  logic [1:0]        rotation_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [HOLD_W-1:0] long_press_r;
  logic [RAW_W-1:0]  move_limit_r, swipe_thr_r;
  logic              invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r   <= ROTATION_RST;
      width_r      <= WIDTH_RST;
      height_r     <= HEIGHT_RST;
      long_press_r <= LONG_PRESS_RST;
      move_limit_r <= MOVE_LIMIT_RST;
      swipe_thr_r  <= SWIPE_THR_RST;
      invert_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POINT_ROTATION:  rotation_r   <= cfg_wdata[1:0];
        REG_SCREEN_WIDTH:    width_r      <= cfg_wdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT:   height_r     <= cfg_wdata[SIZE_W-1:0];
        REG_LONG_PRESS_MS:   long_press_r <= cfg_wdata[HOLD_W-1:0];
        REG_TAP_MOVE_LIMIT:  move_limit_r <= cfg_wdata[RAW_W-1:0];
        REG_SWIPE_THRESHOLD: swipe_thr_r  <= cfg_wdata[RAW_W-1:0];
        REG_SWIPE_INVERT:    invert_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_free, adv, in_accept;
  logic s1_valid_r, out_valid_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Stage one: parsed report
  logic                 s1_down_r;
  logic [RAW_W-1:0]     s1_rx_r, s1_ry_r;
  logic [TIME_BITS-1:0] s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_down_r <= in_read_ok && ((in_status_byte[3:0] & TOUCH_CNT_MASK) != 4'd0);
      s1_rx_r   <= {in_x_high[3:0], in_x_low};
      s1_ry_r   <= {in_y_high[3:0], in_y_low};
      s1_now_r  <= in_now_ms[TIME_BITS-1:0];
    end
  end

  // Press state
  logic                  touch_held_r, press_active_r, swipe_active_r;
  logic [COORD_BITS-1:0] last_x_r, last_y_r, start_x_r, start_y_r;
  logic [TIME_BITS-1:0]  start_time_r;

  logic                  touch_held_nxt, press_active_nxt, swipe_active_nxt;
  logic [COORD_BITS-1:0] last_x_nxt, last_y_nxt, start_x_nxt, start_y_nxt;
  logic [TIME_BITS-1:0]  start_time_nxt;

  logic                  tap_nxt, swipe_nxt;
  logic [COORD_BITS-1:0] tap_x_nxt, tap_y_nxt;
  logic signed [1:0]     dir_x_nxt, dir_y_nxt;

  // Clamp and rotate
  logic [SIZE_X_W-1:0]   wm_full, hm_full;
  logic [COORD_BITS-1:0] wm, hm, cx, cy, rot_x, rot_y;

  always_comb begin
    wm_full = SIZE_X_W'(width_r) - SIZE_X_W'(1);
    hm_full = SIZE_X_W'(height_r) - SIZE_X_W'(1);
    wm      = wm_full[COORD_BITS-1:0];
    hm      = hm_full[COORD_BITS-1:0];
    cx      = (SIZE_W'(s1_rx_r) >= width_r)  ? wm : COORD_BITS'(s1_rx_r);
    cy      = (SIZE_W'(s1_ry_r) >= height_r) ? hm : COORD_BITS'(s1_ry_r);
    unique case (rot_t'(rotation_r))
      ROT_90: begin
        rot_x = wm - cy;
        rot_y = cx;
      end
      ROT_180: begin
        rot_x = wm - cx;
        rot_y = hm - cy;
      end
      ROT_270: begin
        rot_x = cy;
        rot_y = hm - cx;
      end
      default: begin
        rot_x = cx;
        rot_y = cy;
      end
    endcase
  end

  // Distances from the press start; the sign bit of the wide difference picks the order
  logic [COORD_BITS:0]   dx_diff, dy_diff, lx_diff, ly_diff;
  logic [COORD_BITS-1:0] dx_abs, dy_abs, lx_abs, ly_abs;
  logic [TIME_BITS-1:0]  held;
  logic                  swipe_hit, tap_ok;

  always_comb begin
    dx_diff = {1'b0, rot_x} - {1'b0, start_x_r};
    dy_diff = {1'b0, rot_y} - {1'b0, start_y_r};
    lx_diff = {1'b0, last_x_r} - {1'b0, start_x_r};
    ly_diff = {1'b0, last_y_r} - {1'b0, start_y_r};
    dx_abs  = dx_diff[COORD_BITS] ? (start_x_r - rot_x) : dx_diff[COORD_BITS-1:0];
    dy_abs  = dy_diff[COORD_BITS] ? (start_y_r - rot_y) : dy_diff[COORD_BITS-1:0];
    lx_abs  = lx_diff[COORD_BITS] ? (start_x_r - last_x_r) : lx_diff[COORD_BITS-1:0];
    ly_abs  = ly_diff[COORD_BITS] ? (start_y_r - last_y_r) : ly_diff[COORD_BITS-1:0];
    held    = s1_now_r - start_time_r;

    swipe_hit = (dx_abs >= COORD_BITS'(swipe_thr_r)) ||
                (dy_abs >= COORD_BITS'(swipe_thr_r));
    tap_ok    = !swipe_active_r &&
                (held < TIME_BITS'(long_press_r)) &&
                (lx_abs <= COORD_BITS'(move_limit_r)) &&
                (ly_abs <= COORD_BITS'(move_limit_r));
  end

  always_comb begin
    touch_held_nxt   = touch_held_r;
    press_active_nxt = press_active_r;
    swipe_active_nxt = swipe_active_r;
    last_x_nxt       = last_x_r;
    last_y_nxt       = last_y_r;
    start_x_nxt      = start_x_r;
    start_y_nxt      = start_y_r;
    start_time_nxt   = start_time_r;
    tap_nxt          = 1'b0;
    tap_x_nxt        = '0;
    tap_y_nxt        = '0;
    swipe_nxt        = 1'b0;
    dir_x_nxt        = DIR_NONE;
    dir_y_nxt        = DIR_NONE;

    priority if (s1_down_r) begin
      last_x_nxt     = rot_x;
      last_y_nxt     = rot_y;
      touch_held_nxt = 1'b1;
      if (!press_active_r) begin
        press_active_nxt = 1'b1;
        start_time_nxt   = s1_now_r;
        start_x_nxt      = rot_x;
        start_y_nxt      = rot_y;
      end else if (!swipe_active_r && swipe_hit) begin
        swipe_active_nxt = 1'b1;
        swipe_nxt        = 1'b1;
        // invert flips which side of the start counts as positive
        if (dx_diff == '0)
          dir_x_nxt = DIR_NONE;
        else
          dir_x_nxt = (dx_diff[COORD_BITS] ^ invert_r) ? DIR_NEG : DIR_POS;
        if (dy_diff == '0)
          dir_y_nxt = DIR_NONE;
        else
          dir_y_nxt = (dy_diff[COORD_BITS] ^ invert_r) ? DIR_NEG : DIR_POS;
      end
    end else if (touch_held_r) begin
      touch_held_nxt   = 1'b0;
      swipe_active_nxt = 1'b0;
      press_active_nxt = 1'b0;
      if (tap_ok) begin
        tap_nxt   = 1'b1;
        tap_x_nxt = last_x_r;
        tap_y_nxt = last_y_r;
      end
    end else begin
      // release while not held: no change
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_held_r   <= 1'b0;
      press_active_r <= 1'b0;
      swipe_active_r <= 1'b0;
      last_x_r       <= '0;
      last_y_r       <= '0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      start_time_r   <= '0;
    end else if (adv) begin
      touch_held_r   <= touch_held_nxt;
      press_active_r <= press_active_nxt;
      swipe_active_r <= swipe_active_nxt;
      last_x_r       <= last_x_nxt;
      last_y_r       <= last_y_nxt;
      start_x_r      <= start_x_nxt;
      start_y_r      <= start_y_nxt;
      start_time_r   <= start_time_nxt;
    end
  end

  // Result register; state fields come straight from the press state,
  // which only moves when a result is loaded
  logic                  tap_r, swipe_r;
  logic [COORD_BITS-1:0] tap_x_r, tap_y_r;
  logic signed [1:0]     dir_x_r, dir_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r   <= tap_nxt;
      tap_x_r <= tap_x_nxt;
      tap_y_r <= tap_y_nxt;
      swipe_r <= swipe_nxt;
      dir_x_r <= dir_x_nxt;
      dir_y_r <= dir_y_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_touching    = touch_held_r;
  assign out_live_x      = OUT_W'(last_x_r);
  assign out_live_y      = OUT_W'(last_y_r);
  assign out_tap_event   = tap_r;
  assign out_tap_x       = OUT_W'(tap_x_r);
  assign out_tap_y       = OUT_W'(tap_y_r);
  assign out_swipe_event = swipe_r;
  assign out_swipe_dir_x = dir_x_r;
  assign out_swipe_dir_y = dir_y_r;
  assign out_swiping     = swipe_active_r;

endmodule

### sv/ttsd_checker.sv
module ttsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_touching,
  input logic [ttsd_pkg::OUT_W-1:0]      out_live_x,
  input logic                            out_tap_event,
  input logic [ttsd_pkg::OUT_W-1:0]      out_tap_x,
  input logic [ttsd_pkg::OUT_W-1:0]      out_tap_y,
  input logic                            out_swipe_event,
  input logic                            out_swiping
);
  import ttsd_pkg::*;

  // A tap comes only on a release, a swipe only while pressed
  a_tap_swipe_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tap_event && out_swipe_event))
    else $error("tap and swipe in the same transaction");

  a_tap_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tap_event) |-> (out_tap_x == '0 && out_tap_y == '0))
    else $error("tap position not zero without a tap");

  a_swipe_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_swipe_event) |-> (out_swiping && out_touching))
    else $error("swipe flagged without an active swiping touch");

  a_tap_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tap_event) |-> (!out_touching && !out_swiping))
    else $error("tap flagged while still touching or swiping");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_live_x)))
    else $error("stalled result changed");

endmodule

bind touch_tap_swipe_detector ttsd_checker u_ttsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_touching    (out_touching),
  .out_live_x      (out_live_x),
  .out_tap_event   (out_tap_event),
  .out_tap_x       (out_tap_x),
  .out_tap_y       (out_tap_y),
  .out_swipe_event (out_swipe_event),
  .out_swiping     (out_swiping)
);
